// ===== design/descriptor_slot_allocator_core_assert.svh =====
// Assertion macros for the descriptor slot allocator core.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define DSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dsa_pkg.sv =====
// Types, codes and helpers for the descriptor slot allocator.
`default_nettype none
package dsa_pkg;

	localparam logic [2:0] KIND_ALLOC    = 3'd0;
	localparam logic [2:0] KIND_FREE     = 3'd1;
	localparam logic [2:0] KIND_CLRBUSY  = 3'd2;
	localparam logic [2:0] KIND_RESERVE  = 3'd3;
	localparam logic [2:0] KIND_RELEASE  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 11;
	localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_SLOTS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PTR_ACCESS   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PTR_FLAGS    = 2'd2;

	localparam logic [10:0] RESET_KERNEL_SLOTS = 11'd8;
	localparam logic [7:0]  RESET_PTR_ACCESS   = 8'd240;
	localparam logic [3:0]  RESET_PTR_FLAGS    = 4'd4;

	localparam logic [19:0] PTR_SEG_LIMIT = 20'd4;
	localparam logic [63:0] DESC_BUSY_MASK = 64'h0000_0200_0000_0000;
	localparam logic [63:0] DESC_USE_MASK  = 64'h00ff_0000_0000_0000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] seg_base;
		logic [19:0] seg_limit;
		logic [7:0]  access_byte;
		logic [3:0]  flag_bits;
		logic [31:0] ptr_address;
		logic [9:0]  slot_index;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot_out;
		logic [63:0] descriptor;
	} result_t;

	typedef struct packed {
		logic we;
		logic set;
	} map_wr_t;

	function automatic logic [63:0] pack_desc(input logic [31:0] base, input logic [19:0] limit,
		input logic [7:0] acc, input logic [3:0] flg);
		pack_desc = {base[31:24], flg, limit[19:16], acc, base[23:0], limit[15:0]};
	endfunction

endpackage
`default_nettype wire

// ===== design/dsa_ram.sv =====
// Single-port-write, registered-read memory for the slot tables.
`default_nettype none
module dsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== design/dsa_bitmap.sv =====
// Free-slot bitmap limbs with a lowest-free-bit search over one limb, skipping kernel slots and slot 0.
`default_nettype none
module dsa_bitmap #(
	parameter int NUM_SLOTS = 1024,
	parameter int LIMB_BITS = 32,
	localparam int LIMB_COUNT = (NUM_SLOTS + LIMB_BITS - 1) / LIMB_BITS,
	localparam int LW = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1,
	localparam int BW = $clog2(LIMB_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [10:0]          kcount,
	input  logic [LW-1:0]        rd_limb,
	input  dsa_pkg::map_wr_t     wr,
	input  logic [LW-1:0]        wr_limb,
	input  logic [BW-1:0]        wr_bit,
	output logic [LIMB_BITS-1:0] limb_word,
	output logic                 hit,
	output logic [BW-1:0]        pos
);
	import dsa_pkg::*;

	localparam int TW = $clog2(NUM_SLOTS + LIMB_BITS) + 1;
	localparam int SW = (TW > 12) ? TW : 12;

	logic [LIMB_BITS-1:0] map_q [LIMB_COUNT];
	logic [LIMB_BITS-1:0] masked;
	logic [SW-1:0]        base;
	logic [SW-1:0]        thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LIMB_COUNT; l++) begin
				for (int j = 0; j < LIMB_BITS; j++) begin
					map_q[l][j] <= ((l * LIMB_BITS + j) >= int'(RESET_KERNEL_SLOTS))
						&& ((l * LIMB_BITS + j) < NUM_SLOTS);
				end
			end
		end else if (wr.we) begin
			map_q[wr_limb][wr_bit] <= wr.set;
		end
	end

	always_comb begin
		limb_word = map_q[rd_limb];
		base = SW'(32'(rd_limb) * LIMB_BITS);
		thr = (kcount == 11'd0) ? SW'(1) : SW'(kcount);
		for (int j = 0; j < LIMB_BITS; j++) begin
			masked[j] = limb_word[j] && ((base + SW'(j)) >= thr);
		end
		hit = |masked;
		pos = '0;
		for (int j = LIMB_BITS - 1; j >= 0; j--) begin
			if (masked[j]) begin
				pos = BW'(j);
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/descriptor_slot_allocator_core.sv =====
// Top level: request sequencer of the descriptor slot allocator.
// After reset the block sweeps both slot tables to zero with busy high; configuration
// writes are taken during that time. A request is taken when start is high and busy low,
// and done is high for exactly one cycle when its one result shows on result, where it
// stays until the next result; the receiver cannot stall it. The sequencer walks one table
// entry or one bitmap limb per cycle: allocate walks the bitmap limbs, free walks the limbs
// up to the slot's limb, then reads and writes back; clear busy reads and writes back;
// reserve and release search the reservation memory by address, plus a bitmap walk for a
// new reservation or the slot lookup of a release.
`default_nettype none
module descriptor_slot_allocator_core #(
	parameter int NUM_SLOTS  = 1024,
	parameter int LIMB_BITS  = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  dsa_pkg::request_t                  request,
	output logic                               done,
	output dsa_pkg::result_t                   result,
	input  logic                               cfg_we,
	input  logic [dsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dsa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import dsa_pkg::*;

	localparam int AW = $clog2(NUM_SLOTS);
	localparam int LIMB_COUNT = (NUM_SLOTS + LIMB_BITS - 1) / LIMB_BITS;
	localparam int LW = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
	localparam int BW = $clog2(LIMB_BITS);
	localparam int TW = $clog2(NUM_SLOTS + LIMB_BITS) + 1;
	localparam int RW = 1 + 32 + COUNT_BITS;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_DECODE = 8'b0000_0100,
		S_LOCATE = 8'b0000_1000,
		S_READ   = 8'b0001_0000,
		S_WB     = 8'b0010_0000,
		S_RSCAN  = 8'b0100_0000,
		S_MSCAN  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	request_t req_q;
	result_t result_q;
	logic done_q;
	logic [10:0] kcount_q;
	logic [7:0] pacc_q;
	logic [3:0] pflg_q;
	logic [AW-1:0] clr_q;
	logic [AW:0] scan_q;
	logic [AW-1:0] idx_s1;
	logic vld_s1;
	logic [LW-1:0] limb_q;
	logic [LW-1:0] loc_limb_q;
	logic [TW-1:0] loc_base_q;
	logic [BW-1:0] bit_q;

	logic fin;
	logic [1:0] fin_st;
	logic [9:0] fin_slot;
	logic [63:0] fin_desc;
	logic desc_we, resv_we;
	logic [AW-1:0] desc_wa, resv_wa, resv_ra, slot_a, f_a;
	logic [63:0] desc_wd, desc_rd, desc_new;
	logic [RW-1:0] resv_wd, resv_rd;
	map_wr_t map_wr;
	logic [LW-1:0] map_wl, map_rl;
	logic [BW-1:0] map_wb, map_pos;
	logic [LIMB_BITS-1:0] limb_word;
	logic map_hit;
	logic slot_ok, slot_prot, loc_done, r_hit, r_miss;
	logic rd_valid;
	logic [31:0] rd_addr;
	logic [COUNT_BITS-1:0] rd_cnt, cnt_dec;
	logic [TW-1:0] target;

	dsa_ram #(.WIDTH(64), .DEPTH(NUM_SLOTS)) u_desc (
		.clk(clk), .we(desc_we), .waddr(desc_wa), .wdata(desc_wd),
		.raddr(slot_a), .rdata(desc_rd)
	);

	dsa_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_resv (
		.clk(clk), .we(resv_we), .waddr(resv_wa), .wdata(resv_wd),
		.raddr(resv_ra), .rdata(resv_rd)
	);

	dsa_bitmap #(.NUM_SLOTS(NUM_SLOTS), .LIMB_BITS(LIMB_BITS)) u_map (
		.clk(clk), .arst_n(arst_n), .kcount(kcount_q), .rd_limb(map_rl),
		.wr(map_wr), .wr_limb(map_wl), .wr_bit(map_wb),
		.limb_word(limb_word), .hit(map_hit), .pos(map_pos)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

	assign slot_a = AW'(req_q.slot_index);
	assign slot_ok = 32'(req_q.slot_index) < 32'(NUM_SLOTS);
	assign slot_prot = (req_q.slot_index == 10'd0) || ({1'b0, req_q.slot_index} < kcount_q);
	assign target = TW'(req_q.slot_index);
	assign loc_done = target < (loc_base_q + TW'(LIMB_BITS));
	assign resv_ra = (state_q == S_RSCAN) ? scan_q[AW-1:0] : slot_a;
	assign map_rl = (state_q == S_MSCAN) ? limb_q : loc_limb_q;
	assign rd_valid = resv_rd[RW-1];
	assign rd_addr = resv_rd[RW-2 -: 32];
	assign rd_cnt = resv_rd[COUNT_BITS-1:0];
	assign cnt_dec = (rd_cnt == '0) ? '0 : rd_cnt - COUNT_BITS'(1);
	assign r_hit = vld_s1 && rd_valid && (rd_addr == req_q.ptr_address);
	assign r_miss = !vld_s1 && (scan_q == (AW+1)'(NUM_SLOTS));
	assign f_a = AW'(32'(limb_q) * LIMB_BITS + 32'(map_pos));
	assign desc_new = (req_q.kind == KIND_ALLOC)
		? pack_desc(req_q.seg_base, req_q.seg_limit, req_q.access_byte, req_q.flag_bits)
		: pack_desc(req_q.ptr_address, PTR_SEG_LIMIT, pacc_q, pflg_q);

	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		fin_st = ST_BAD;
		fin_slot = '0;
		fin_desc = '0;
		desc_we = 1'b0;
		desc_wa = slot_a;
		desc_wd = desc_rd & ~DESC_USE_MASK;
		resv_we = 1'b0;
		resv_wa = slot_a;
		resv_wd = '0;
		map_wr = '0;
		map_wl = loc_limb_q;
		map_wb = bit_q;
		case (state_q)
			S_CLEAR: begin
				desc_we = 1'b1;
				desc_wa = clr_q;
				desc_wd = '0;
				resv_we = 1'b1;
				resv_wa = clr_q;
				if (clr_q == AW'(NUM_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (req_q.kind)
					KIND_ALLOC: begin
						if (req_q.flag_bits == 4'd0 && req_q.seg_limit[19:16] == 4'd0) begin
							fin = 1'b1;
						end else begin
							state_d = S_MSCAN;
						end
					end
					KIND_FREE: begin
						if (!slot_ok || slot_prot) begin
							fin = 1'b1;
						end else begin
							state_d = S_LOCATE;
						end
					end
					KIND_CLRBUSY: begin
						if (!slot_ok) begin
							fin = 1'b1;
						end else begin
							state_d = S_READ;
						end
					end
					KIND_RESERVE: state_d = S_RSCAN;
					KIND_RELEASE: begin
						if (!slot_ok) begin
							fin = 1'b1;
						end else begin
							state_d = S_RSCAN;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			S_LOCATE: begin
				if (loc_done) begin
					state_d = S_READ;
				end
			end
			S_READ: state_d = S_WB;
			S_WB: begin
				fin = 1'b1;
				case (req_q.kind)
					KIND_FREE: begin
						if (!limb_word[bit_q] && !rd_valid) begin
							desc_we = 1'b1;
							map_wr = '{we: 1'b1, set: 1'b1};
							fin_st = ST_OK;
						end
					end
					KIND_CLRBUSY: begin
						if ((desc_rd & DESC_USE_MASK) != '0) begin
							desc_we = 1'b1;
							desc_wd = desc_rd & ~DESC_BUSY_MASK;
							fin_desc = desc_rd & ~DESC_BUSY_MASK;
							fin_st = ST_OK;
						end
					end
					KIND_RELEASE: begin
						resv_we = 1'b1;
						fin_st = ST_OK;
						if (cnt_dec == '0) begin
							desc_we = 1'b1;
							map_wr = '{we: 1'b1, set: 1'b1};
						end else begin
							resv_wd = {1'b1, rd_addr, cnt_dec};
						end
					end
					default: fin_st = ST_BAD;
				endcase
			end
			S_RSCAN: begin
				if (r_hit) begin
					if (req_q.kind == KIND_RESERVE) begin
						fin = 1'b1;
						if (rd_cnt != '1) begin
							resv_we = 1'b1;
							resv_wa = idx_s1;
							resv_wd = {1'b1, rd_addr, rd_cnt + COUNT_BITS'(1)};
							fin_st = ST_OK;
							fin_slot = 10'(idx_s1);
						end
					end else if (idx_s1 == slot_a) begin
						state_d = S_LOCATE;
					end else begin
						fin = 1'b1;
					end
				end else if (r_miss) begin
					if (req_q.kind == KIND_RESERVE && pflg_q != 4'd0) begin
						state_d = S_MSCAN;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_MSCAN: begin
				if (map_hit) begin
					fin = 1'b1;
					fin_st = ST_OK;
					fin_slot = 10'(f_a);
					fin_desc = desc_new;
					desc_we = 1'b1;
					desc_wa = f_a;
					desc_wd = desc_new;
					map_wr = '{we: 1'b1, set: 1'b0};
					map_wl = limb_q;
					map_wb = map_pos;
					if (req_q.kind == KIND_RESERVE) begin
						resv_we = 1'b1;
						resv_wa = f_a;
						resv_wd = {1'b1, req_q.ptr_address, COUNT_BITS'(1)};
					end
				end else if (limb_q == LW'(LIMB_COUNT - 1)) begin
					fin = 1'b1;
					fin_st = ST_FULL;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q <= 1'b0;
			clr_q <= '0;
			scan_q <= '0;
			vld_s1 <= 1'b0;
			limb_q <= '0;
			loc_limb_q <= '0;
			loc_base_q <= '0;
			bit_q <= '0;
			kcount_q <= RESET_KERNEL_SLOTS;
			pacc_q <= RESET_PTR_ACCESS;
			pflg_q <= RESET_PTR_FLAGS;
		end else begin
			state_q <= state_d;
			done_q <= fin;
			if (cfg_we) begin
				case (cfg_index)
					CFG_KERNEL_SLOTS: kcount_q <= cfg_wdata;
					CFG_PTR_ACCESS:   pacc_q <= cfg_wdata[7:0];
					CFG_PTR_FLAGS:    pflg_q <= cfg_wdata[3:0];
					default:          kcount_q <= kcount_q;
				endcase
			end
			case (state_q)
				S_CLEAR: clr_q <= clr_q + AW'(1);
				S_DECODE: begin
					scan_q <= '0;
					vld_s1 <= 1'b0;
					limb_q <= '0;
					loc_limb_q <= '0;
					loc_base_q <= '0;
				end
				S_RSCAN: begin
					vld_s1 <= scan_q < (AW+1)'(NUM_SLOTS);
					idx_s1 <= scan_q[AW-1:0];
					if (scan_q < (AW+1)'(NUM_SLOTS)) begin
						scan_q <= scan_q + (AW+1)'(1);
					end
				end
				S_LOCATE: begin
					if (loc_done) begin
						bit_q <= BW'(target - loc_base_q);
					end else begin
						loc_base_q <= loc_base_q + TW'(LIMB_BITS);
						loc_limb_q <= loc_limb_q + LW'(1);
					end
				end
				S_MSCAN: limb_q <= limb_q + LW'(1);
				default: vld_s1 <= vld_s1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= request;
		end
		if (fin) begin
			result_q <= '{status: fin_st, slot_out: fin_slot, descriptor: fin_desc};
		end
	end

	`include "descriptor_slot_allocator_core_assert.svh"

	`DSA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transfer did not raise busy")
	`DSA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`DSA_ASSERT_NOW(a_status_code, done, result.status != 2'd3, "undefined status code")
	`DSA_ASSERT_NOW(a_no_store_clear, state_q == S_CLEAR, !done, "result during clearing pass")
endmodule
`default_nettype wire
